// ----- hw/rtl/bsa_pkg.sv -----
// bsa_pkg: shared types and constants for the bitmap slot allocator
// no dependencies; used by bsa_ctrl, bsa_datapath and bitmap_slot_allocator
package bsa_pkg;

    typedef enum logic [1:0]
    {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    localparam int          RESV_WORD = 7;
    localparam logic [31:0] RESV_BITS = 32'hFFFF_0000;
    localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;
    localparam logic [15:0] RESV_LO   = 16'h00F0;
    localparam logic [15:0] RESV_HI   = 16'h00FF;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    typedef struct packed
    {
        logic load;
        logic rd_en;
        logic rd_slot;
        logic capture;
        logic commit;
        logic full;
        logic free_wr;
        logic clear;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic [1:0] in_op;
        logic       free_ok;
        logic       rd_valid;
        logic       found;
        logic       last_tag;
        logic       issue_done;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- hw/rtl/bsa_datapath.sv -----
// bsa_datapath: map memory with per-word valid bits, scan pointer, first-zero
// search, high-water mark and output register; depends on bsa_pkg
module bsa_datapath
#(
    parameter int SLOTS = 512
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [bsa_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [1:0]                         s_tuser,
    input  bsa_pkg::dp_cmd_t                   cmd,
    output bsa_pkg::dp_stat_t                  stat,
    output logic [bsa_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    localparam int MAP_WORDS = SLOTS / 32;
    localparam int MAP_SPAN  = MAP_WORDS * 32;
    localparam int WORD_W    = $clog2(MAP_WORDS);
    localparam int SLOT_W    = WORD_W + 5;
    localparam int PTR_W     = WORD_W + 1;
    localparam int OUT_DATA_W_LOCAL = bsa_pkg::OUT_DATA_W;

    logic [15:0]       limit_reg;
    logic [3:0]        pick_reg;
    logic [15:0]       slot_reg;

    logic [31:0]       map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;

    logic [PTR_W-1:0]  issue_reg;
    logic [31:0]       rd_word_reg;
    logic              rd_vld_reg;
    logic [WORD_W-1:0] rd_tag_reg;
    logic              rd_valid_reg;

    logic [SLOT_W-1:0] found_slot_reg;
    logic              spill_reg;
    logic [31:0]       set_word_reg;

    logic              hm_none_reg;
    logic [SLOT_W-1:0] hm_reg;

    logic [8:0]        res_slot_reg;
    logic              res_spill_reg;
    logic              res_full_reg;

    logic [OUT_DATA_W_LOCAL-1:0] out_data_reg;
    logic [1:0]        out_user_reg;
    logic              out_valid_reg;

    logic [31:0]       eff_word;
    logic [4:0]        zero_pos;
    logic [SLOT_W-1:0] cand_slot;
    logic [WORD_W-1:0] slot_word;
    logic [WORD_W-1:0] rd_addr;
    logic [31:0]       clr_word;
    logic              wr_en;
    logic [WORD_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic [9:0]        high_water;

    assign eff_word = rd_vld_reg ? rd_word_reg :
                      ((rd_tag_reg == WORD_W'(bsa_pkg::RESV_WORD)) ? bsa_pkg::RESV_BITS : '0);

    always_comb
    begin
        zero_pos = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!eff_word[i])
            begin
                zero_pos = 5'(i);
            end
        end
    end

    assign cand_slot = {rd_tag_reg, zero_pos};
    assign slot_word = slot_reg[WORD_W+4:5];
    assign rd_addr   = cmd.rd_slot ? slot_word : issue_reg[WORD_W-1:0];
    assign clr_word  = eff_word & ~(32'd1 << slot_reg[4:0]);

    assign wr_en   = (cmd.commit && !spill_reg) || cmd.free_wr;
    assign wr_addr = cmd.commit ? found_slot_reg[SLOT_W-1:5] : slot_word;
    assign wr_data = cmd.commit ? set_word_reg : clr_word;

    assign high_water = hm_none_reg ? '1 : 10'(hm_reg);

    // status to the controller
    assign stat.in_op      = s_tuser;
    assign stat.free_ok    = (slot_reg < 16'(MAP_SPAN))
                             && !((slot_reg >= bsa_pkg::RESV_LO) && (slot_reg <= bsa_pkg::RESV_HI));
    assign stat.rd_valid   = rd_valid_reg;
    assign stat.found      = (eff_word != bsa_pkg::FULL_WORD);
    assign stat.last_tag   = (rd_tag_reg == WORD_W'(MAP_WORDS - 1));
    assign stat.issue_done = (issue_reg == PTR_W'(MAP_WORDS));
    assign stat.out_free   = !out_valid_reg || m_tready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            limit_reg <= s_tdata[15:0];
            pick_reg  <= s_tdata[19:16];
            slot_reg  <= s_tdata[35:20];
        end
    end

    // map memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_word_reg <= map_mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
            rd_tag_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            issue_reg    <= '0;
            hm_none_reg  <= 1'b1;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                issue_reg <= '0;
            end
            else if (cmd.rd_en && !cmd.rd_slot)
            begin
                issue_reg <= issue_reg + PTR_W'(1);
            end
            if (cmd.clear)
            begin
                valid_reg   <= '0;
                hm_none_reg <= 1'b1;
            end
            else
            begin
                if (wr_en)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                if (cmd.commit && (hm_none_reg || (found_slot_reg > hm_reg)))
                begin
                    hm_none_reg <= 1'b0;
                end
            end
        end
    end

    // found slot, high-water mark and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            found_slot_reg <= cand_slot;
            spill_reg      <= (16'(cand_slot) > limit_reg);
            set_word_reg   <= eff_word | (32'd1 << zero_pos);
        end
        if (cmd.commit && (hm_none_reg || (found_slot_reg > hm_reg)))
        begin
            hm_reg <= found_slot_reg;
        end
        if (cmd.load)
        begin
            res_slot_reg  <= '0;
            res_spill_reg <= 1'b0;
            res_full_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_slot_reg  <= spill_reg ? (9'(bsa_pkg::RESV_LO) + 9'(pick_reg))
                                       : 9'(found_slot_reg);
            res_spill_reg <= spill_reg;
        end
        else if (cmd.full)
        begin
            res_full_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {5'd0, high_water, res_slot_reg};
            out_user_reg <= {res_full_reg, res_spill_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// ----- hw/rtl/bsa_ctrl.sv -----
// bsa_ctrl: sequencing state machine for allocate, free, clear and unknown-operation words
// depends on bsa_pkg; drives bsa_datapath through dp_cmd_t
module bsa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bsa_pkg::dp_stat_t  stat,
    output bsa_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    priority if (stat.in_op == bsa_pkg::OP_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (stat.in_op == bsa_pkg::OP_FREE)
                    begin
                        state_next = ST_FREE_RD;
                    end
                    else if (stat.in_op == bsa_pkg::OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = !stat.issue_done;
                if (stat.rd_valid && stat.found)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COMMIT;
                end
                else if (stat.rd_valid && stat.last_tag)
                begin
                    cmd.full   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FREE_RD:
            begin
                if (stat.free_ok)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_slot = 1'b1;
                    state_next  = ST_FREE_WR;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// ----- hw/rtl/bitmap_slot_allocator.sv -----
// Bitmap slot allocator: first-free slot allocation over a map of SLOTS/32
// 32-bit words held in one memory (one read, one write port, registered read).
// Slots 240..255 are always taken. An allocate word scans the map one word per
// cycle from word 0 and stops at the first word with a free slot, or reports
// the map full after the last word; free reads the slot's word and writes it
// back with the slot cleared, skipping both when the slot is reserved or out
// of range. The map needs no clearing pass: per-word valid bits make unwritten
// words read as their reset value, and clear drops them all at once. A finished
// result waits in the output register while the next word is accepted; it is
// loaded only once that register is free.
// Depends on bsa_pkg, bsa_ctrl, bsa_datapath
module bitmap_slot_allocator
#(
    parameter int SLOTS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // limit[15:0], reserve_pick[19:16], slot[35:20], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // slot_out[8:0], high_water[18:9], zero pad
    output logic [1:0]  m_tuser    // spilled[0], full_res[1]
);

    bsa_pkg::dp_cmd_t  cmd;
    bsa_pkg::dp_stat_t stat;

    bsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsa_datapath #(.SLOTS(SLOTS)) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for bitmap_slot_allocator, driving request words on the
// input stream and checking every result word against a slot-map predictor
// depends on bsa_pkg and the bitmap_slot_allocator rtl
module tb;

    localparam int         MAP_SLOTS   = 512;
    localparam int         MAP_WORDS   = MAP_SLOTS / 32;
    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         TOTAL_ITEMS = 1750;
    localparam int         QUIET_TAIL  = 150;
    localparam int         HOLD_CYCLES = 500;
    localparam int         HOLD_AFTER  = 150;
    localparam int         STALL_LIMIT = 4000;
    localparam int         MAX_REPORTS = 10;
    localparam int         TAIL_CYCLES = 40;

    typedef struct packed
    {
        logic [1:0]  op;
        logic [15:0] limit;
        logic [3:0]  pick;
        logic [15:0] slot;
    } slot_req_t;

    typedef struct packed
    {
        logic [8:0]        slot_out;
        logic              spilled;
        logic              full;
        logic signed [9:0] high_water;
    } slot_res_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [31:0]       alloc_map [MAP_WORDS];
    logic signed [9:0] hw_mark;

    slot_req_t req_pending [$];
    slot_res_t due_results [$];
    slot_req_t offered;
    slot_res_t seen;
    slot_res_t want;

    bit word_in_taken = 1'b0;
    bit hold_done     = 1'b0;
    int words_in      = 0;
    int results_in    = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    int total_items   = 0;
    int in_gap        = 0;
    int in_window     = 0;
    int in_mode       = 0;
    int out_gap       = 0;
    int out_window    = 0;
    int out_mode      = 0;
    int hold_left     = 0;

    bitmap_slot_allocator #(.SLOTS(MAP_SLOTS)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // limit[15:0], reserve_pick[19:16], slot[35:20], zero pad
        .s_tuser  (s_tuser),   // operation[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // slot_out[8:0], high_water[18:9], zero pad
        .m_tuser  (m_tuser)    // spilled[0], full_res[1]
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_model_map();
        for (int w = 0; w < MAP_WORDS; w++)
            alloc_map[w] = '0;
        alloc_map[bsa_pkg::RESV_WORD] = bsa_pkg::RESV_BITS;
        hw_mark = -10'sd1;
    endfunction

    function automatic void drop_model_slot(int unsigned s);
        if (s < MAP_SLOTS && !(s >= bsa_pkg::RESV_LO && s <= bsa_pkg::RESV_HI))
            alloc_map[s >> 5][s & 31] = 1'b0;
    endfunction

    function automatic slot_res_t predict_alloc(slot_req_t r);
        slot_res_t o;
        int pos;
        o = '0;
        pos = -1;
        if (r.op == bsa_pkg::OP_ALLOC)
        begin
            for (int w = 0; w < MAP_WORDS && pos < 0; w++)
                if (alloc_map[w] != bsa_pkg::FULL_WORD)
                    for (int b = 0; b < 32 && pos < 0; b++)
                        if (!alloc_map[w][b])
                            pos = w * 32 + b;
            if (pos < 0)
                o.full = 1'b1;
            else
            begin
                alloc_map[pos >> 5][pos & 31] = 1'b1;
                if (pos > hw_mark)
                    hw_mark = pos[9:0];
                if (pos > int'(r.limit))
                begin
                    drop_model_slot(pos);
                    o.slot_out = 9'(bsa_pkg::RESV_LO) + {5'd0, r.pick};
                    o.spilled  = 1'b1;
                end
                else
                    o.slot_out = pos[8:0];
            end
        end
        else if (r.op == bsa_pkg::OP_FREE)
            drop_model_slot(r.slot);
        else if (r.op == bsa_pkg::OP_CLEAR)
            clear_model_map();
        o.high_water = hw_mark;
        return o;
    endfunction

    task automatic push_req(logic [1:0] op, int unsigned lim, int unsigned pick,
                            int unsigned slot);
        slot_req_t r;
        r.op    = op;
        r.limit = lim[15:0];
        r.pick  = pick[3:0];
        r.slot  = slot[15:0];
        req_pending.push_back(r);
    endtask

    // driver: request words change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || word_in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (req_pending.size() > 0)
            begin
                offered = req_pending.pop_front();
                s_tdata  <= {4'd0, offered.slot, offered.pick, offered.limit};
                s_tuser  <= offered.op;
                s_tvalid <= 1'b1;
                if (req_pending.size() > QUIET_TAIL && in_mode != 0
                    && $urandom_range(0, in_mode * 4) == 0)
                    in_gap = $urandom_range(1, 18);
            end
            else
                s_tvalid <= 1'b0;
        end
        word_in_taken = 1'b0;
        if (in_window == 0)
        begin
            in_window = $urandom_range(50, 300);
            in_mode   = $urandom_range(0, 2);
        end
        else
            in_window--;
    end

    // receiver: long hold-off once, then random stall bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && words_in >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            m_tready <= 1'b0;
        end
        else if (req_pending.size() > QUIET_TAIL && out_mode != 0
                 && $urandom_range(0, out_mode * 4) == 0)
        begin
            out_gap = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
        if (out_window == 0)
        begin
            out_window = $urandom_range(50, 300);
            out_mode   = $urandom_range(0, 2);
        end
        else
            out_window--;
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            word_in_taken = 1'b1;
            words_in++;
            due_results.push_back(predict_alloc(offered));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            results_in++;
            seen.slot_out   = m_tdata[8:0];
            seen.high_water = m_tdata[18:9];
            seen.spilled    = m_tuser[0];
            seen.full       = m_tuser[1];
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d with none due: slot %0d spill %0b full %0b hw %0d",
                             results_in, seen.slot_out, seen.spilled, seen.full,
                             $signed(seen.high_water));
            end
            else
            begin
                want = due_results.pop_front();
                if (seen.slot_out != want.slot_out || seen.spilled != want.spilled
                    || seen.full != want.full || seen.high_water != want.high_water)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: exp %0d %0b %0b %0d got %0d %0b %0b %0d",
                                 results_in, want.slot_out, want.spilled, want.full,
                                 $signed(want.high_water), seen.slot_out,
                                 seen.spilled, seen.full, $signed(seen.high_water));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int depth;
        int fills;
        int n;
        int kind;
        int unsigned lim;
        depth = 0;
        fills = 0;
        clear_model_map();

        // directed: limits at both ends, spill picks, ignored frees, unused op
        push_req(bsa_pkg::OP_ALLOC, 16'hFFFF, 4'h0, 16'h0000);
        push_req(bsa_pkg::OP_ALLOC, 16'h0000, 4'hF, 16'hFFFF);
        push_req(bsa_pkg::OP_ALLOC, 16'h0000, 4'h0, 16'h0000);
        push_req(bsa_pkg::OP_FREE,  16'h0000, 4'h0, 16'h0000);
        push_req(bsa_pkg::OP_ALLOC, 16'h0000, 4'h7, 16'h0000);
        push_req(bsa_pkg::OP_ALLOC, 16'h0001, 4'h8, 16'h0000);
        push_req(bsa_pkg::OP_FREE,  16'hFFFF, 4'hF, 16'd240);
        push_req(bsa_pkg::OP_FREE,  16'h0000, 4'h0, 16'd255);
        push_req(bsa_pkg::OP_FREE,  16'h0000, 4'h0, 16'd512);
        push_req(bsa_pkg::OP_FREE,  16'h0000, 4'h0, 16'hFFFF);
        push_req(bsa_pkg::OP_FREE,  16'h0000, 4'h0, 16'd239);
        push_req(OP_NONE,           16'hFFFF, 4'hF, 16'hFFFF);
        push_req(OP_NONE,           16'h0000, 4'h0, 16'h0000);
        push_req(bsa_pkg::OP_ALLOC, 16'h0002, 4'h3, 16'h0000);
        push_req(bsa_pkg::OP_ALLOC, 16'h0002, 4'hC, 16'h0000);
        push_req(bsa_pkg::OP_FREE,  16'h0000, 4'h0, 16'd1);
        push_req(bsa_pkg::OP_ALLOC, 16'hFFFF, 4'h0, 16'h0000);
        push_req(bsa_pkg::OP_CLEAR, 16'hFFFF, 4'hF, 16'hFFFF);
        push_req(bsa_pkg::OP_ALLOC, 16'h0000, 4'hA, 16'h0000);
        push_req(bsa_pkg::OP_ALLOC, 16'h0000, 4'h5, 16'h0000);
        push_req(bsa_pkg::OP_CLEAR, 16'h0000, 4'h0, 16'h0000);
        push_req(bsa_pkg::OP_FREE,  16'h0000, 4'h0, 16'd0);
        push_req(bsa_pkg::OP_ALLOC, 16'h8000, 4'h1, 16'h8000);
        depth = 1;

        while (req_pending.size() < TOTAL_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (fills < 2 && req_pending.size() > 500 * (fills + 1))
                kind = 20;
            if (kind <= 13)
            begin
                if (kind >= 12)
                begin
                    push_req(bsa_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
                    depth = 0;
                end
                n = $urandom_range(8, 40);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) < 7)
                    begin
                        case ($urandom_range(0, 3))
                            0:       lim = $urandom_range(0, depth + 24);
                            1:       lim = $urandom;
                            default: lim = 16'hFFFF;
                        endcase
                        push_req(bsa_pkg::OP_ALLOC, lim, $urandom, $urandom);
                        depth++;
                    end
                    else
                        push_req(bsa_pkg::OP_FREE, $urandom, $urandom,
                                 $urandom_range(0, (depth + 20 > 511) ? 511 : depth + 20));
                end
            end
            else if (kind <= 16)
            begin
                n = $urandom_range(3, 8);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0: push_req(OP_NONE, $urandom, $urandom, $urandom);
                        1: push_req(bsa_pkg::OP_FREE, $urandom, $urandom,
                                    $urandom_range(240, 255));
                        2: push_req(bsa_pkg::OP_FREE, $urandom, $urandom,
                                    $urandom_range(512, 65535));
                        default: push_req(bsa_pkg::OP_FREE, $urandom, $urandom, $urandom);
                    endcase
                end
            end
            else if (kind <= 19)
            begin
                // interrupted sequence: clear in the middle of work
                push_req(bsa_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
                push_req(bsa_pkg::OP_ALLOC, 0, $urandom, $urandom);
                push_req(bsa_pkg::OP_ALLOC, 0, $urandom, $urandom);
                push_req(bsa_pkg::OP_FREE, $urandom, $urandom, 0);
                push_req(bsa_pkg::OP_ALLOC, $urandom_range(0, 3), $urandom, $urandom);
                push_req(OP_NONE, $urandom, $urandom, $urandom);
                push_req(bsa_pkg::OP_FREE, $urandom, $urandom, $urandom);
                depth = 2;
            end
            else
            begin
                // fill the map past full, punch holes, refill
                fills++;
                if ($urandom_range(0, 1) == 0)
                    push_req(bsa_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
                repeat (505)
                    push_req(bsa_pkg::OP_ALLOC, 16'hFFFF, $urandom, $urandom);
                repeat (6)
                    push_req(bsa_pkg::OP_FREE, $urandom, $urandom, $urandom_range(0, 511));
                repeat (10)
                    push_req(bsa_pkg::OP_ALLOC, $urandom_range(0, 511), $urandom, $urandom);
                repeat (3)
                    push_req(bsa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
                depth = 496;
            end
        end
        total_items = req_pending.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_in < total_items || due_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- bitmap_slot_allocator.f -----
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_datapath.sv
hw/rtl/bsa_ctrl.sv
hw/rtl/bitmap_slot_allocator.sv
bench/tb.sv
